[rtl/altb_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// altb_pkg
// Shared types and constants of the array list table engine.
// ============================================================================
package altb_pkg;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int STS_W  = 3;
	localparam int IDX_W  = 4;
	localparam int SUM_W  = 36;
	localparam int CNT_W  = 5;

	localparam int MAX_RESULTS = 16;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CNT_W-1:0] CAP_RESET    = 5'd10;
	localparam logic             REG_CAPACITY = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND  = 3'd0,
		CMD_INSERT  = 3'd1,
		CMD_DELETE  = 3'd2,
		CMD_LSEARCH = 3'd3,
		CMD_BSEARCH = 3'd4,
		CMD_REVERSE = 3'd5,
		CMD_DUMP    = 3'd6,
		CMD_NOP     = 3'd7
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_BAD_INDEX = 3'd2,
		STS_NOT_FOUND = 3'd3,
		STS_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DEL_GET,
		ST_MOVE,
		ST_LSEARCH,
		ST_BS_PROBE,
		ST_BS_CMP,
		ST_REV_RA,
		ST_REV_RB,
		ST_REV_WA,
		ST_REV_WB,
		ST_DUMP_RD,
		ST_DUMP_OUT,
		ST_EMIT
	} state_t;

endpackage

[rtl/altb_cmd_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// altb_cmd_if
// Command channel: one beat carries one list command.
// ============================================================================
interface altb_cmd_if;
	import altb_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] item_value;
	logic signed [DATA_W-1:0] search_key;

	modport source (output valid, command, position, item_value, search_key, input ready);
	modport sink   (input valid, command, position, item_value, search_key, output ready);

endinterface

[rtl/altb_rsp_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// altb_rsp_if
// Result channel: one beat per result, last marks the end of a command.
// ============================================================================
interface altb_rsp_if;
	import altb_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STS_W-1:0]         status;
	logic [IDX_W-1:0]         found_index;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [SUM_W-1:0]  total;
	logic [CNT_W-1:0]         count;
	logic                     last;

	modport source (output valid, status, found_index, entry_value, total, count, last,
		input ready);
	modport sink   (input valid, status, found_index, entry_value, total, count, last,
		output ready);

endinterface

[rtl/altb_apb_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// altb_apb_regs
// APB register block holding the capacity register.
// ============================================================================
module altb_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [altb_pkg::APB_AW-1:0] paddr,
	input  logic [altb_pkg::APB_DW-1:0] pwdata,
	output logic [altb_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output logic [altb_pkg::CNT_W-1:0]  capacity
);
	import altb_pkg::*;

	logic [CNT_W-1:0] cap_q;
	logic             reg_idx;
	logic             wr_en;

	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite && (reg_idx == REG_CAPACITY);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_en) begin
			cap_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		if (reg_idx == REG_CAPACITY) begin
			prdata = APB_DW'(cap_q);
		end else begin
			prdata = '0;
		end
	end

	assign capacity = cap_q;

endmodule

[rtl/array_list_table_engine_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// array_list_table_engine_top
// Packed list of signed 32-bit entries with append, insert, delete, searches,
// reverse and dump, run by a sequencer over a single-port-read memory.
// ============================================================================
// Commands are taken one at a time; cmd.ready is high only while the
// sequencer is idle, and a waiting result does not hold off the next command.
// Every entry read goes through the one read port of the entry memory,
// whose registered read data sets the pace. Insert and delete shift the
// entries behind the position one place, linear search reads entries in
// order until a match, binary search probes midpoints, reverse swaps pairs
// from both ends inward, and dump reads entries one by one; a stalled
// output holds off the sequencer. The memory needs no clearing after
// reset: only entries below count are ever read.
// ============================================================================
module array_list_table_engine_top #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	altb_cmd_if.sink                    cmd,
	altb_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [altb_pkg::APB_AW-1:0] paddr,
	input  logic [altb_pkg::APB_DW-1:0] pwdata,
	output logic [altb_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import altb_pkg::*;

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_MAX = (DEPTH > 31) ? 31 : DEPTH;

	localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_MAX);
	localparam logic [CNT_W-1:0] DUMP_LIM = CNT_W'(MAX_RESULTS);

	logic [CNT_W-1:0] capacity;
	logic [CNT_W-1:0] cap_eff;

	altb_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	assign cap_eff = (capacity < CAP_LIM) ? capacity : CAP_LIM;

	// entry memory
	logic [DATA_W-1:0] mem [DEPTH];
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// sequencer state
	state_t            state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [DATA_W-1:0] item_q, item_d;
	logic [DATA_W-1:0] key_q, key_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [CNT_W-1:0]  src_q, src_d;
	logic [CNT_W-1:0]  rem_q, rem_d;
	logic              pend_q, pend_d;
	logic [CNT_W-1:0]  pdst_q, pdst_d;
	logic [CNT_W-1:0]  lo_q, lo_d;
	logic [CNT_W-1:0]  hix_q, hix_d;
	logic [CNT_W-1:0]  mid_q, mid_d;
	logic [CNT_W-1:0]  n_q, n_d;
	logic [DATA_W-1:0] tmp_q, tmp_d;
	status_t           res_sts_q, res_sts_d;
	logic [IDX_W-1:0]  res_idx_q, res_idx_d;
	logic [DATA_W-1:0] res_val_q, res_val_d;

	// output register
	logic              ovalid_q, ovalid_d;
	logic [STS_W-1:0]  osts_q, osts_d;
	logic [IDX_W-1:0]  oidx_q, oidx_d;
	logic [DATA_W-1:0] oval_q, oval_d;
	logic [SUM_W-1:0]  otot_q, otot_d;
	logic [CNT_W-1:0]  ocnt_q, ocnt_d;
	logic              olast_q, olast_d;

	logic              out_free;
	logic              cmd_take;
	logic [CNT_W:0]    mid_sum;
	logic [SUM_W-1:0]  item_ext;
	logic [SUM_W-1:0]  res_ext;

	assign out_free  = !ovalid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hix_q} - (CNT_W+1)'(1);
	assign item_ext  = {{(SUM_W-DATA_W){item_q[DATA_W-1]}}, item_q};
	assign res_ext   = {{(SUM_W-DATA_W){res_val_q[DATA_W-1]}}, res_val_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			sum_q    <= '0;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			sum_q    <= sum_d;
			pend_q   <= pend_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		pos_q     <= pos_d;
		item_q    <= item_d;
		key_q     <= key_d;
		src_q     <= src_d;
		rem_q     <= rem_d;
		pdst_q    <= pdst_d;
		lo_q      <= lo_d;
		hix_q     <= hix_d;
		mid_q     <= mid_d;
		n_q       <= n_d;
		tmp_q     <= tmp_d;
		res_sts_q <= res_sts_d;
		res_idx_q <= res_idx_d;
		res_val_q <= res_val_d;
		osts_q    <= osts_d;
		oidx_q    <= oidx_d;
		oval_q    <= oval_d;
		otot_q    <= otot_d;
		ocnt_q    <= ocnt_d;
		olast_q   <= olast_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		pos_d     = pos_q;
		item_d    = item_q;
		key_d     = key_q;
		fill_d    = fill_q;
		sum_d     = sum_q;
		src_d     = src_q;
		rem_d     = rem_q;
		pend_d    = pend_q;
		pdst_d    = pdst_q;
		lo_d      = lo_q;
		hix_d     = hix_q;
		mid_d     = mid_q;
		n_d       = n_q;
		tmp_d     = tmp_q;
		res_sts_d = res_sts_q;
		res_idx_d = res_idx_q;
		res_val_d = res_val_q;

		ovalid_d  = ovalid_q && !rsp.ready;
		osts_d    = osts_q;
		oidx_d    = oidx_q;
		oval_d    = oval_q;
		otot_d    = otot_q;
		ocnt_d    = ocnt_q;
		olast_d   = olast_q;

		mem_we    = 1'b0;
		mem_waddr = AW'(fill_q);
		mem_wdata = item_q;
		mem_re    = 1'b0;
		mem_raddr = AW'(src_q);

		case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					cmd_d   = cmd_t'(cmd.command);
					pos_d   = cmd.position;
					item_d  = cmd.item_value;
					key_d   = cmd.search_key;
					state_d = ST_DECODE;
				end
			end

			ST_DECODE: begin
				res_sts_d = STS_OK;
				res_idx_d = '0;
				res_val_d = '0;
				pend_d    = 1'b0;
				state_d   = ST_EMIT;
				case (cmd_q)
					CMD_APPEND: begin
						if (fill_q >= cap_eff) begin
							res_sts_d = STS_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = AW'(fill_q);
							mem_wdata = item_q;
							fill_d    = fill_q + CNT_W'(1);
							sum_d     = sum_q + item_ext;
						end
					end
					CMD_INSERT: begin
						if (pos_q > fill_q) begin
							res_sts_d = STS_BAD_INDEX;
						end else if (fill_q >= cap_eff) begin
							res_sts_d = STS_FULL;
						end else begin
							src_d   = fill_q - CNT_W'(1);
							rem_d   = fill_q - pos_q;
							state_d = ST_MOVE;
						end
					end
					CMD_DELETE: begin
						if (fill_q == '0) begin
							res_sts_d = STS_EMPTY;
						end else if (pos_q >= fill_q) begin
							res_sts_d = STS_BAD_INDEX;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = AW'(pos_q);
							state_d   = ST_DEL_GET;
						end
					end
					CMD_LSEARCH: begin
						if (fill_q == '0) begin
							res_sts_d = STS_EMPTY;
						end else begin
							src_d   = '0;
							rem_d   = fill_q;
							state_d = ST_LSEARCH;
						end
					end
					CMD_BSEARCH: begin
						if (fill_q == '0) begin
							res_sts_d = STS_EMPTY;
						end else begin
							lo_d    = '0;
							hix_d   = fill_q;
							state_d = ST_BS_PROBE;
						end
					end
					CMD_REVERSE: begin
						lo_d    = '0;
						hix_d   = fill_q;
						state_d = ST_REV_RA;
					end
					CMD_DUMP: begin
						if (fill_q == '0) begin
							res_sts_d = STS_EMPTY;
						end else begin
							n_d     = (fill_q > DUMP_LIM) ? DUMP_LIM : fill_q;
							src_d   = '0;
							state_d = ST_DUMP_RD;
						end
					end
					default: begin
						res_sts_d = STS_OK;
					end
				endcase
			end

			ST_DEL_GET: begin
				res_val_d = rdata_q;
				src_d     = pos_q + POS_W'(1);
				rem_d     = fill_q - pos_q - CNT_W'(1);
				state_d   = ST_MOVE;
			end

			// entries shift one place, read and write overlapped
			ST_MOVE: begin
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pdst_q);
					mem_wdata = rdata_q;
				end
				if (rem_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(src_q);
					pend_d    = 1'b1;
					rem_d     = rem_q - CNT_W'(1);
					if (cmd_q == CMD_INSERT) begin
						pdst_d = src_q + CNT_W'(1);
						src_d  = src_q - CNT_W'(1);
					end else begin
						pdst_d = src_q - CNT_W'(1);
						src_d  = src_q + CNT_W'(1);
					end
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						res_sts_d = STS_OK;
						state_d   = ST_EMIT;
						if (cmd_q == CMD_INSERT) begin
							mem_we    = 1'b1;
							mem_waddr = AW'(pos_q);
							mem_wdata = item_q;
							fill_d    = fill_q + CNT_W'(1);
							sum_d     = sum_q + item_ext;
						end else begin
							fill_d    = fill_q - CNT_W'(1);
							sum_d     = sum_q - res_ext;
						end
					end
				end
			end

			ST_LSEARCH: begin
				if (pend_q && (rdata_q == key_q)) begin
					pend_d    = 1'b0;
					res_sts_d = STS_OK;
					res_idx_d = pdst_q[IDX_W-1:0];
					state_d   = ST_EMIT;
				end else if (rem_q == '0 && !pend_q) begin
					res_sts_d = STS_NOT_FOUND;
					state_d   = ST_EMIT;
				end else if (rem_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(src_q);
					pend_d    = 1'b1;
					pdst_d    = src_q;
					src_d     = src_q + CNT_W'(1);
					rem_d     = rem_q - CNT_W'(1);
				end else begin
					pend_d = 1'b0;
				end
			end

			ST_BS_PROBE: begin
				if (lo_q < hix_q) begin
					mid_d     = mid_sum[CNT_W:1];
					mem_re    = 1'b1;
					mem_raddr = AW'(mid_sum[CNT_W:1]);
					state_d   = ST_BS_CMP;
				end else begin
					res_sts_d = STS_NOT_FOUND;
					state_d   = ST_EMIT;
				end
			end

			ST_BS_CMP: begin
				if (key_q == rdata_q) begin
					res_sts_d = STS_OK;
					res_idx_d = mid_q[IDX_W-1:0];
					state_d   = ST_EMIT;
				end else begin
					if ($signed(key_q) < $signed(rdata_q)) begin
						hix_d = mid_q;
					end else begin
						lo_d  = mid_q + CNT_W'(1);
					end
					state_d = ST_BS_PROBE;
				end
			end

			ST_REV_RA: begin
				if (({1'b0, lo_q} + (CNT_W+1)'(1)) < {1'b0, hix_q}) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(lo_q);
					state_d   = ST_REV_RB;
				end else begin
					res_sts_d = STS_OK;
					state_d   = ST_EMIT;
				end
			end

			ST_REV_RB: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(hix_q - CNT_W'(1));
				tmp_d     = rdata_q;
				state_d   = ST_REV_WA;
			end

			ST_REV_WA: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(lo_q);
				mem_wdata = rdata_q;
				state_d   = ST_REV_WB;
			end

			ST_REV_WB: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(hix_q - CNT_W'(1));
				mem_wdata = tmp_q;
				lo_d      = lo_q + CNT_W'(1);
				hix_d     = hix_q - CNT_W'(1);
				state_d   = ST_REV_RA;
			end

			ST_DUMP_RD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(src_q);
				state_d   = ST_DUMP_OUT;
			end

			ST_DUMP_OUT: begin
				if (out_free) begin
					ovalid_d = 1'b1;
					osts_d   = STS_OK;
					oidx_d   = src_q[IDX_W-1:0];
					oval_d   = rdata_q;
					otot_d   = sum_q;
					ocnt_d   = fill_q;
					olast_d  = ((src_q + CNT_W'(1)) == n_q);
					if ((src_q + CNT_W'(1)) == n_q) begin
						state_d = ST_IDLE;
					end else begin
						src_d   = src_q + CNT_W'(1);
						state_d = ST_DUMP_RD;
					end
				end
			end

			ST_EMIT: begin
				if (out_free) begin
					ovalid_d = 1'b1;
					osts_d   = res_sts_q;
					oidx_d   = res_idx_q;
					oval_d   = res_val_q;
					otot_d   = sum_q;
					ocnt_d   = fill_q;
					olast_d  = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp.valid       = ovalid_q;
	assign rsp.status      = osts_q;
	assign rsp.found_index = oidx_q;
	assign rsp.entry_value = oval_q;
	assign rsp.total       = otot_q;
	assign rsp.count       = ocnt_q;
	assign rsp.last        = olast_q;

endmodule

[verif/array_list_table_engine_top_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// array_list_table_engine_top_test
// Self-checking bench for the list engine. A mirror of the list predicts the
// result beats of every accepted command and checks each returned beat in
// order. A directed opening covers empty, full and bad-index cases, and the
// extreme values. Random bursts follow: sorted fills with binary searches,
// and mixed command runs. Capacity changes between bursts, and both channels
// stall at random.
// ============================================================================
module array_list_table_engine_top_test;
	import altb_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 480;
	localparam int QUIET_TAIL   = 60;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;

	typedef struct packed {
		cmd_t                     command;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
		logic signed [DATA_W-1:0] search_key;
	} list_cmd_t;

	typedef struct packed {
		status_t                  status;
		logic [IDX_W-1:0]         found_index;
		logic signed [DATA_W-1:0] entry_value;
		logic signed [SUM_W-1:0]  total;
		logic [CNT_W-1:0]         count;
		logic                     last;
	} list_result_t;

	class list_mirror;
		logic signed [DATA_W-1:0] slots [DEPTH];
		int                       fill;
		logic [SUM_W-1:0]         sum;
		int                       cap_reg;
		int                       errors;
		list_result_t             due_results [$];

		function new();
			fill    = 0;
			sum     = '0;
			cap_reg = CAP_RESET;
			errors  = 0;
		endfunction

		function void set_capacity(int value);
			cap_reg = value;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function logic [SUM_W-1:0] extend(logic signed [DATA_W-1:0] v);
			return SUM_W'(v);
		endfunction

		function void post(status_t st, int idx, logic signed [DATA_W-1:0] val, bit fin);
			list_result_t r;
			r.status      = st;
			r.found_index = IDX_W'(idx);
			r.entry_value = val;
			r.total       = sum;
			r.count       = CNT_W'(fill);
			r.last        = fin;
			due_results.push_back(r);
		endfunction

		function void take_command(list_cmd_t c);
			int                       lim;
			int                       pos;
			int                       i;
			int                       lo;
			int                       hi;
			int                       mid;
			int                       hit;
			logic signed [DATA_W-1:0] key;
			logic signed [DATA_W-1:0] held;
			lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
			pos = c.position;
			key = c.search_key;
			hit = -1;
			case (c.command)
			CMD_APPEND: begin
				if (fill >= lim) begin
					post(STS_FULL, 0, '0, 1'b1);
				end else begin
					slots[fill] = c.item_value;
					fill++;
					sum += extend(c.item_value);
					post(STS_OK, 0, '0, 1'b1);
				end
			end
			CMD_INSERT: begin
				if (pos > fill) begin
					post(STS_BAD_INDEX, 0, '0, 1'b1);
				end else if (fill >= lim) begin
					post(STS_FULL, 0, '0, 1'b1);
				end else begin
					for (i = fill; i > pos; i--)
						slots[i] = slots[i-1];
					slots[pos] = c.item_value;
					fill++;
					sum += extend(c.item_value);
					post(STS_OK, 0, '0, 1'b1);
				end
			end
			CMD_DELETE: begin
				if (fill == 0) begin
					post(STS_EMPTY, 0, '0, 1'b1);
				end else if (pos >= fill) begin
					post(STS_BAD_INDEX, 0, '0, 1'b1);
				end else begin
					held = slots[pos];
					for (i = pos; i < fill - 1; i++)
						slots[i] = slots[i+1];
					fill--;
					sum -= extend(held);
					post(STS_OK, 0, held, 1'b1);
				end
			end
			CMD_LSEARCH: begin
				if (fill == 0) begin
					post(STS_EMPTY, 0, '0, 1'b1);
				end else begin
					for (i = 0; i < fill && hit < 0; i++)
						if (slots[i] == key)
							hit = i;
					if (hit >= 0)
						post(STS_OK, hit, '0, 1'b1);
					else
						post(STS_NOT_FOUND, 0, '0, 1'b1);
				end
			end
			CMD_BSEARCH: begin
				if (fill == 0) begin
					post(STS_EMPTY, 0, '0, 1'b1);
				end else begin
					lo = 0;
					hi = fill - 1;
					while (lo <= hi && hit < 0) begin
						mid = (lo + hi) / 2;
						if (key == slots[mid])
							hit = mid;
						else if (key < slots[mid])
							hi = mid - 1;
						else
							lo = mid + 1;
					end
					if (hit >= 0)
						post(STS_OK, hit, '0, 1'b1);
					else
						post(STS_NOT_FOUND, 0, '0, 1'b1);
				end
			end
			CMD_REVERSE: begin
				lo = 0;
				hi = fill - 1;
				while (lo < hi) begin
					held      = slots[lo];
					slots[lo] = slots[hi];
					slots[hi] = held;
					lo++;
					hi--;
				end
				post(STS_OK, 0, '0, 1'b1);
			end
			CMD_DUMP: begin
				if (fill == 0) begin
					post(STS_EMPTY, 0, '0, 1'b1);
				end else begin
					for (i = 0; i < fill; i++)
						post(STS_OK, i, slots[i], i == fill - 1);
				end
			end
			default: begin
				post(STS_OK, 0, '0, 1'b1);
			end
			endcase
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
			if (want !== got) begin
				errors++;
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				$error("result beat with no command outstanding (status %0d, count %0d)",
					got.status, got.count);
				return;
			end
			want = due_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("found_index", want.found_index, got.found_index);
			compare_field("entry_value", $signed(want.entry_value), $signed(got.entry_value));
			compare_field("total", $signed(want.total), $signed(got.total));
			compare_field("count", want.count, got.count);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	altb_cmd_if cmd ();
	altb_rsp_if rsp ();

	list_mirror mirror = new();
	bit         idling_on;
	int         items_sent;

	array_list_table_engine_top #(
		.DEPTH (DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic list_cmd_t make_cmd(cmd_t op, int pos, logic signed [DATA_W-1:0] val,
		logic signed [DATA_W-1:0] key);
		list_cmd_t c;
		c.command    = op;
		c.position   = POS_W'(pos);
		c.item_value = val;
		c.search_key = key;
		return c;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
		0: begin
			case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			default: return '1;
			endcase
		end
		1, 2, 3: return DATA_W'($urandom_range(0, 8)) - 4;
		default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_key();
		if (mirror.fill > 0 && $urandom_range(0, 1) == 1)
			return mirror.slots[$urandom_range(0, mirror.fill - 1)];
		return pick_value();
	endfunction

	function automatic list_cmd_t random_cmd();
		int   roll;
		int   pos;
		cmd_t op;
		roll = $urandom_range(0, 99);
		op = roll < 25 ? CMD_APPEND  :
		     roll < 45 ? CMD_INSERT  :
		     roll < 65 ? CMD_DELETE  :
		     roll < 75 ? CMD_LSEARCH :
		     roll < 83 ? CMD_BSEARCH :
		     roll < 89 ? CMD_REVERSE :
		     roll < 97 ? CMD_DUMP    : CMD_NOP;
		pos = $urandom_range(0, 16);
		if ($urandom_range(0, 4) != 0) begin
			if (op == CMD_INSERT)
				pos = $urandom_range(0, mirror.fill);
			else if (op == CMD_DELETE && mirror.fill > 0)
				pos = $urandom_range(0, mirror.fill - 1);
		end
		return make_cmd(op, pos, pick_value(), pick_key());
	endfunction

	// Valid stays high from one beat to the next unless a gap is taken.
	task automatic send_command(list_cmd_t c);
		int gap;
		gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.command    <= c.command;
		cmd.position   <= c.position;
		cmd.item_value <= c.item_value;
		cmd.search_key <= c.search_key;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		mirror.take_command(c);
		items_sent++;
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (mirror.pending() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(int value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_CAPACITY, 2'b00};
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		mirror.set_capacity(value);
	endtask

	// Clear the list, refill it in ascending order, probe it sorted and reversed, then dump it.
	task automatic sorted_run();
		int vals [$];
		int lim;
		while (mirror.fill > 0)
			send_command(make_cmd(CMD_DELETE, 0, pick_value(), pick_value()));
		lim = (mirror.cap_reg < DEPTH) ? mirror.cap_reg : DEPTH;
		if (lim > 0)
			repeat ($urandom_range(1, lim)) vals.push_back(pick_value());
		vals.sort();
		foreach (vals[i])
			send_command(make_cmd(CMD_APPEND, $urandom_range(0, 16), vals[i], pick_value()));
		repeat ($urandom_range(2, 6))
			send_command(make_cmd(CMD_BSEARCH, $urandom_range(0, 16), pick_value(), pick_key()));
		send_command(make_cmd(CMD_REVERSE, $urandom_range(0, 16), pick_value(), pick_key()));
		repeat (2)
			send_command(make_cmd(CMD_BSEARCH, $urandom_range(0, 16), pick_value(), pick_key()));
		send_command(make_cmd(CMD_DUMP, $urandom_range(0, 16), pick_value(), pick_key()));
	endtask

	initial begin
		list_result_t seen;
		int           stall;
		stall      = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				seen.status      = status_t'(rsp.status);
				seen.found_index = rsp.found_index;
				seen.entry_value = rsp.entry_value;
				seen.total       = rsp.total;
				seen.count       = rsp.count;
				seen.last        = rsp.last;
				mirror.check_result(seen);
			end
			if (stall > 0)
				stall--;
			else if (idling_on && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 5);
			rsp.ready <= (stall == 0);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int phase;
		int opening;
		arst_n         <= 1'b0;
		cmd.valid      <= 1'b0;
		cmd.command    <= CMD_NOP;
		cmd.position   <= '0;
		cmd.item_value <= '0;
		cmd.search_key <= '0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		idling_on      <= 1'b1;
		items_sent      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, bad index, full, unsorted probe, unused code, capacity under count
		write_capacity(3);
		send_command(make_cmd(CMD_DELETE, 0, 0, 0));
		send_command(make_cmd(CMD_LSEARCH, 0, 0, 0));
		send_command(make_cmd(CMD_BSEARCH, 0, 0, 0));
		send_command(make_cmd(CMD_DUMP, 0, 0, 0));
		send_command(make_cmd(CMD_REVERSE, 0, 0, 0));
		send_command(make_cmd(CMD_INSERT, 1, 5, 0));
		send_command(make_cmd(CMD_APPEND, 0, 32'h7FFF_FFFF, 0));
		send_command(make_cmd(CMD_REVERSE, 0, 0, 0));
		send_command(make_cmd(CMD_INSERT, 0, 32'h8000_0000, 0));
		send_command(make_cmd(CMD_APPEND, 0, 0, 0));
		send_command(make_cmd(CMD_APPEND, 0, 7, 0));
		send_command(make_cmd(CMD_INSERT, 4, 9, 0));
		send_command(make_cmd(CMD_INSERT, 3, 9, 0));
		send_command(make_cmd(CMD_LSEARCH, 0, 0, 0));
		send_command(make_cmd(CMD_LSEARCH, 0, 0, 5));
		send_command(make_cmd(CMD_BSEARCH, 0, 0, 0));
		send_command(make_cmd(CMD_REVERSE, 0, 0, 0));
		send_command(make_cmd(CMD_DUMP, 0, 0, 0));
		send_command(make_cmd(CMD_DELETE, 3, 0, 0));
		send_command(make_cmd(CMD_NOP, 16, '1, '1));
		send_command(make_cmd(CMD_DELETE, 1, 0, 0));
		write_capacity(1);
		send_command(make_cmd(CMD_APPEND, 0, 1, 0));
		send_command(make_cmd(CMD_DELETE, 0, 0, 0));
		write_capacity(0);
		send_command(make_cmd(CMD_APPEND, 0, 2, 0));
		send_command(make_cmd(CMD_INSERT, 0, 3, 0));

		opening = items_sent;
		phase   = 0;
		while (items_sent < opening + RANDOM_ITEMS) begin
			if (phase < 3 || $urandom_range(0, 3) == 0) begin
				case (phase)
				0:       write_capacity(16);
				1:       write_capacity(31);
				2:       write_capacity(1);
				default: write_capacity($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 16));
				endcase
			end
			idling_on <= (items_sent < opening + RANDOM_ITEMS - QUIET_TAIL) &&
				($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) == 0)
				sorted_run();
			else
				repeat ($urandom_range(10, 30)) send_command(random_cmd());
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
